@@ rtl/htep_pkg.sv @@
// Shared types and constants of the Huffman table encoder and bit packer.
package htep_pkg;

  localparam int BYTE_W      = 8;
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 32;
  localparam int LEN_W       = 6;
  localparam int PEND_W      = 7;
  localparam int CNT_W       = 3;
  localparam int REM_W       = 6;
  localparam int ACC_W       = PEND_W + CODE_W;
  localparam int TOTAL_W     = 40;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               byte_valid;
    logic               is_last;
    logic [TOTAL_W-1:0] total_bits;
  } out_item_t;

  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

@@ rtl/htep_front.sv @@
// Front end: accepts transactions, owns the code table, issues packer commands.
module htep_front import htep_pkg::*; #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_item_t item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_ready
);

  localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CAP_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LEN_CAP   = LEN_W'(CAP_LEN);
  localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W+1)'(SYMBOL_COUNT);

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] filled;

  logic              accept, in_range, wr_en, rd_en, s1_free;
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  load_len, eff_len;
  logic              s1_valid, s1_flush, s1_hit, rd_filled;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic [2*CODE_W-1:0] mask;

  assign in_range = {1'b0, item.symbol} < SYM_LIMIT;
  assign idx      = item.symbol[IDX_W-1:0];
  assign load_len = (item.code_length > LEN_CAP) ? LEN_CAP : item.code_length;

  assign eff_len   = rd_filled ? rd_len : '0;
  assign cmd_valid = s1_valid && (s1_flush || (s1_hit && eff_len != '0));
  assign mask      = ((2*CODE_W)'(1) << eff_len) - (2*CODE_W)'(1);
  assign cmd.is_flush = s1_flush;
  assign cmd.code     = rd_code & mask[CODE_W-1:0];
  assign cmd.len      = eff_len;

  assign s1_free    = !s1_valid || !cmd_valid || cmd_ready;
  assign item_stall = !s1_free;
  assign accept     = item_valid && s1_free;
  assign wr_en      = accept && item.opcode == OP_LOAD && in_range;
  assign rd_en      = accept && item.opcode == OP_ENCODE && in_range;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[idx] <= item.code_value;
      len_mem[idx]  <= load_len;
    end
    if (rd_en) begin
      rd_code   <= code_mem[idx];
      rd_len    <= len_mem[idx];
      rd_filled <= filled[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= item.opcode == OP_ENCODE || item.opcode == OP_FLUSH;
    end else if (s1_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush <= item.opcode == OP_FLUSH;
      s1_hit   <= in_range;
    end
  end

endmodule

@@ rtl/htep_queue.sv @@
// Command queue between the front end and the bit packer.
module htep_queue import htep_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push, do_pop;

  assign push_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/htep_back.sv @@
// Bit packer: accumulates code bits, emits bytes and flush reports.
module htep_back import htep_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  localparam logic [REM_W-1:0] BYTE_REM = REM_W'(BYTE_W);

  logic [PEND_W-1:0]  pend;
  logic [CNT_W-1:0]   cnt;
  logic [TOTAL_W-1:0] total;
  logic               busy;
  logic [ACC_W-1:0]   acc;
  logic [REM_W-1:0]   rem;

  logic               out_free, go, emit, flush_sel, full_byte;
  logic [ACC_W-1:0]   start_acc, cur_acc;
  logic [REM_W-1:0]   start_rem, cur_rem, rem_after, fin_cnt;
  logic [PEND_W-1:0]  pend_new;
  logic [BYTE_W-1:0]  emit_byte, flush_byte;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_next;

  assign out_free  = !result_valid || !result_stall;
  assign cmd_pop   = !busy && cmd_valid && out_free;
  assign go        = busy ? out_free : cmd_pop;
  assign flush_sel = cmd_pop && cmd.is_flush;

  assign start_acc = (ACC_W'(pend) << cmd.len) | ACC_W'(cmd.code);
  assign start_rem = REM_W'(cnt) + cmd.len;
  assign cur_acc   = busy ? acc : start_acc;
  assign cur_rem   = busy ? rem : start_rem;
  assign full_byte = cur_rem >= BYTE_REM;
  assign rem_after = cur_rem - BYTE_REM;
  assign fin_cnt   = full_byte ? rem_after : cur_rem;
  assign emit      = go && !flush_sel && full_byte;

  assign pend_new   = cur_acc[PEND_W-1:0] &
                      PEND_W'((BYTE_W'(1) << fin_cnt[CNT_W-1:0]) - BYTE_W'(1));
  assign emit_byte  = BYTE_W'(cur_acc >> rem_after);
  assign flush_byte = BYTE_W'({1'b0, pend} << (4'(BYTE_W) - {1'b0, cnt}));

  assign total_sum  = {1'b0, total} + (TOTAL_W+1)'(cmd.len);
  assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pend         <= '0;
      cnt          <= '0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit || flush_sel) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (flush_sel) begin
        pend  <= '0;
        cnt   <= '0;
        total <= '0;
      end else if (go) begin
        if (cmd_pop) begin
          total <= total_next;
        end
        if (full_byte && rem_after >= BYTE_REM) begin
          busy <= 1'b1;
        end else begin
          busy <= 1'b0;
          pend <= pend_new;
          cnt  <= fin_cnt[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= cur_acc;
      rem <= rem_after;
    end
    if (flush_sel) begin
      result.data_byte  <= flush_byte;
      result.byte_valid <= cnt != '0;
      result.is_last    <= 1'b1;
      result.total_bits <= total;
    end else if (emit) begin
      result.data_byte  <= emit_byte;
      result.byte_valid <= 1'b1;
      result.is_last    <= rem_after < BYTE_REM;
      result.total_bits <= '0;
    end
  end

endmodule

@@ rtl/huffman_table_encoder_packer.sv @@
// Top level of the table-driven Huffman encoder and bit packer.
//
// Input channel item/item_valid/item_stall carries one transaction per
// accepted edge: load a table entry, encode a symbol, or flush.
// Output channel result/result_valid/result_stall carries packed bytes,
// first code bit in the MSB, and one flush report with the bit count.
// A load produces nothing. An encode keeps the packer busy until it has
// emitted every full byte, up to four for a 32-bit code; an encode of an
// unloaded entry or of length zero sends it no command. A flush yields one
// report. The packer is the limit: input transactions keep flowing through
// the front end and the four-entry command queue while the packer emits.
// A command passes the front stage register and queue before the packer.
// The symbol table reads through one registered port; each entry carries a
// valid flag, so reset empties the table at once and no clear sweep runs.
// Reset is synchronous: table, accumulator, bit count and queue are empty.
// When the receiver stalls, the held result stays put, the packer waits,
// the queue fills and then item_stall rises.
module huffman_table_encoder_packer import htep_pkg::*; #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic fq_valid, fq_ready, qb_valid, qb_pop;
  cmd_t fq_cmd, qb_cmd;

  htep_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (fq_valid),
    .cmd        (fq_cmd),
    .cmd_ready  (fq_ready)
  );

  htep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_cmd   (fq_cmd),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_cmd    (qb_cmd),
    .pop        (qb_pop)
  );

  htep_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (qb_valid),
    .cmd          (qb_cmd),
    .cmd_pop      (qb_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.byte_valid |-> result.is_last)
    else $error("empty flush report not marked last");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.total_bits != '0 |-> result.is_last)
    else $error("bit count on a non-final transaction");

  assert property (@(posedge clk) disable iff (rst)
    qb_pop |-> qb_valid)
    else $error("packer popped an empty queue");

endmodule
